/* src/assert_macros.svh */
// assertion macros used by the event stream decoder
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with reset disable and a fixed message
`define ASSERT_CLK(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// clocked assertion with reset disable and a caller message
`define ASSERT_CLK_MSG(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

`endif

/* src/mesd_pkg.sv */
// types, constants and the controller table of the event stream decoder
package mesd_pkg;

    // fixed sizes
    localparam int CHANNEL_COUNT = 16;
    localparam int TICK_BITS_DEFAULT = 28;
    localparam int FPT_W = 16;
    localparam int FRAMES_W = 37;

    localparam logic [FPT_W-1:0] FPT_RESET = 16'd315;
    localparam logic [6:0] VEL_RESET = 7'd100;
    localparam logic [3:0] DRUM_CHANNEL = 4'd9;
    localparam logic [FRAMES_W-1:0] FRAMES_MAX = {FRAMES_W{1'b1}};

    // input op codes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    // event types from the info byte
    localparam logic [2:0] TYPE_OFF = 3'd0;
    localparam logic [2:0] TYPE_ON = 3'd1;
    localparam logic [2:0] TYPE_BEND = 3'd2;
    localparam logic [2:0] TYPE_SYS = 3'd3;
    localparam logic [2:0] TYPE_CTRL = 3'd4;
    localparam logic [2:0] TYPE_UNKNOWN = 3'd7;

    // result kinds
    localparam logic [2:0] KIND_OFF = 3'd0;
    localparam logic [2:0] KIND_ON = 3'd1;
    localparam logic [2:0] KIND_BEND = 3'd2;
    localparam logic [2:0] KIND_CONTROL = 3'd3;
    localparam logic [2:0] KIND_PROGRAM = 3'd4;
    localparam logic [2:0] KIND_NOOP = 3'd5;
    localparam logic [2:0] KIND_UNKNOWN = 3'd6;

    // input transaction
    typedef struct packed {
        logic       op;
        logic [7:0] score_byte;
    } t_in;

    // decoded event without its delay
    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  channel;
        logic [6:0]  key;
        logic [13:0] amount;
        logic        drum;
    } t_evt;

    // output transaction
    typedef struct packed {
        logic [2:0]          kind;
        logic [3:0]          channel;
        logic [6:0]          key;
        logic [13:0]         amount;
        logic                drum;
        logic [FRAMES_W-1:0] wait_frames;
    } t_out;

    // controller number to midi controller, number taken mod 15
    function automatic logic [6:0] ctrl_map(input logic [6:0] num);
        logic [4:0] sum;
        logic [3:0] idx;
        logic [6:0] res;
        // 16 is 1 mod 15, so fold the high nibble onto the low one
        sum = 5'(num[6:4]) + 5'(num[3:0]);
        idx = (sum >= 5'd15) ? 4'(sum - 5'd15) : sum[3:0];
        case (idx)
            4'd0:    res = 7'd0;
            4'd1:    res = 7'd0;
            4'd2:    res = 7'd1;
            4'd3:    res = 7'd7;
            4'd4:    res = 7'd10;
            4'd5:    res = 7'd11;
            4'd6:    res = 7'd91;
            4'd7:    res = 7'd93;
            4'd8:    res = 7'd64;
            4'd9:    res = 7'd67;
            4'd10:   res = 7'd120;
            4'd11:   res = 7'd123;
            4'd12:   res = 7'd126;
            4'd13:   res = 7'd127;
            4'd14:   res = 7'd121;
            default: res = 7'd0;
        endcase
        return res;
    endfunction

endpackage

/* src/mus_event_stream_decoder.sv */
// score byte parser, velocity store and delay scaling of the event stream decoder
//
// usage
// - input channel i_in_valid / o_in_stall carries one score byte or a restart
//   per transaction; a transaction completes when valid is high and stall low
// - output channel o_out_valid / i_out_stall carries one decoded event per
//   transaction, fields kind, channel, key, amount, drum and wait_frames
// - config channel i_cfg_valid / o_cfg_ready writes frames_per_tick; ready is
//   always high, write only while the block is idle
// - one byte per cycle sustained while o_in_stall is low; bytes that finish
//   no event give no result; the byte that completes an event goes into the
//   parse register, then through the tick by frames_per_tick multiply into
//   the output register
// - reset: parser waits for an info byte, all channel velocities are 100,
//   frames_per_tick is 315, both pipeline stages are empty
// - restart transaction: same parser and velocity clear, no result
// - receiver stall: the parse stage and the output register hold one event
//   each; o_in_stall rises only when both are full and the output is stalled
`include "assert_macros.svh"

module mus_event_stream_decoder #(
    parameter int TICK_BITS = mesd_pkg::TICK_BITS_DEFAULT
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  mesd_pkg::t_in             i_in,
    output logic                      o_in_stall,
    output logic                      o_out_valid,
    output mesd_pkg::t_out            o_out,
    input  logic                      i_out_stall,
    input  logic                      i_cfg_valid,
    input  logic [mesd_pkg::FPT_W-1:0] i_cfg_data,
    output logic                      o_cfg_ready
);

    localparam int CH = mesd_pkg::CHANNEL_COUNT;
    localparam int PROD_W = TICK_BITS + mesd_pkg::FPT_W;

    // parser phases
    localparam logic [1:0] PH_INFO = 2'd0;
    localparam logic [1:0] PH_DATA1 = 2'd1;
    localparam logic [1:0] PH_DATA2 = 2'd2;
    localparam logic [1:0] PH_DELAY = 2'd3;

    logic [mesd_pkg::FPT_W-1:0] r_fpt;
    logic [1:0]                 r_phase, n_phase;
    logic [2:0]                 r_type, n_type;
    logic [3:0]                 r_chan, n_chan;
    logic                       r_delay, n_delay;
    logic [7:0]                 r_first, n_first;
    logic [6:0]                 r_second, n_second;
    logic [TICK_BITS-1:0]       r_acc, n_acc;
    logic [6:0]                 r_vel [CH];
    logic [6:0]                 n_vel [CH];

    logic                       r_s1_valid;
    mesd_pkg::t_evt             r_s1_evt;
    logic [TICK_BITS-1:0]       r_s1_ticks;
    logic                       r_out_valid;
    mesd_pkg::t_out             r_out;

    logic                       in_acc;
    logic                       s1_move;
    logic                       emit;
    logic                       done;
    logic [TICK_BITS-1:0]       emit_ticks;
    mesd_pkg::t_evt             evt;
    logic [PROD_W-1:0]          prod;
    logic [63:0]                prod_ext;
    logic [mesd_pkg::FRAMES_W-1:0] frames;

    // pipeline handshake
    assign s1_move = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && r_out_valid && i_out_stall;
    assign in_acc = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out = r_out;
    assign o_cfg_ready = 1'b1;

    // parser next state
    always_comb begin
        n_phase = r_phase;
        n_type = r_type;
        n_chan = r_chan;
        n_delay = r_delay;
        n_first = r_first;
        n_second = r_second;
        n_acc = r_acc;
        n_vel = r_vel;
        done = 1'b0;
        emit = 1'b0;
        emit_ticks = '0;
        if (in_acc) begin
            if (i_in.op == mesd_pkg::OP_RESTART) begin
                n_phase = PH_INFO;
                n_type = '0;
                n_chan = '0;
                n_delay = 1'b0;
                n_first = '0;
                n_second = '0;
                n_acc = '0;
                for (int c = 0; c < CH; c++) begin
                    n_vel[c] = mesd_pkg::VEL_RESET;
                end
            end else begin
                case (r_phase)
                    PH_INFO: begin
                        n_delay = i_in.score_byte[7];
                        n_type = i_in.score_byte[6:4];
                        n_chan = i_in.score_byte[3:0];
                        n_first = '0;
                        n_second = '0;
                        if (i_in.score_byte[6:4] <= mesd_pkg::TYPE_CTRL) begin
                            n_phase = PH_DATA1;
                        end else begin
                            done = 1'b1;
                        end
                    end
                    PH_DATA1: begin
                        n_first = i_in.score_byte;
                        if ((r_type == mesd_pkg::TYPE_ON && i_in.score_byte[7]) ||
                            r_type == mesd_pkg::TYPE_CTRL) begin
                            n_phase = PH_DATA2;
                        end else begin
                            done = 1'b1;
                        end
                    end
                    PH_DATA2: begin
                        if (r_type == mesd_pkg::TYPE_ON) begin
                            n_vel[r_chan] = i_in.score_byte[6:0];
                        end else begin
                            n_second = i_in.score_byte[6:0];
                        end
                        done = 1'b1;
                    end
                    PH_DELAY: begin
                        // saturate once the next shift would leave the tick range
                        if (r_acc[TICK_BITS-1 -: 7] != 7'd0) begin
                            n_acc = '1;
                        end else begin
                            n_acc = TICK_BITS'({r_acc, i_in.score_byte[6:0]});
                        end
                        if (!i_in.score_byte[7]) begin
                            emit = 1'b1;
                            emit_ticks = n_acc;
                            n_phase = PH_INFO;
                        end
                    end
                    default: begin
                        n_phase = PH_INFO;
                    end
                endcase
                // data complete: either start the delay or emit now
                if (done) begin
                    if (n_delay) begin
                        n_phase = PH_DELAY;
                        n_acc = '0;
                    end else begin
                        emit = 1'b1;
                        n_phase = PH_INFO;
                    end
                end
            end
        end
    end

    // event fields from the updated parser state
    always_comb begin
        evt.kind = mesd_pkg::KIND_NOOP;
        evt.channel = n_chan;
        evt.key = '0;
        evt.amount = '0;
        evt.drum = 1'b0;
        case (n_type)
            mesd_pkg::TYPE_OFF: begin
                evt.kind = mesd_pkg::KIND_OFF;
                evt.key = n_first[6:0];
            end
            mesd_pkg::TYPE_ON: begin
                evt.kind = mesd_pkg::KIND_ON;
                evt.key = n_first[6:0];
                evt.amount = {7'd0, n_vel[n_chan]};
            end
            mesd_pkg::TYPE_BEND: begin
                evt.kind = mesd_pkg::KIND_BEND;
                evt.amount = {n_first, 6'd0};
            end
            mesd_pkg::TYPE_SYS: begin
                evt.kind = mesd_pkg::KIND_CONTROL;
                evt.key = mesd_pkg::ctrl_map(n_first[6:0]);
            end
            mesd_pkg::TYPE_CTRL: begin
                if (n_first[6:0] == 7'd0) begin
                    evt.kind = mesd_pkg::KIND_PROGRAM;
                    evt.key = n_second;
                    evt.drum = (n_chan == mesd_pkg::DRUM_CHANNEL);
                end else begin
                    evt.kind = mesd_pkg::KIND_CONTROL;
                    evt.key = mesd_pkg::ctrl_map(n_first[6:0]);
                    evt.amount = {7'd0, n_second};
                end
            end
            mesd_pkg::TYPE_UNKNOWN: begin
                evt.kind = mesd_pkg::KIND_UNKNOWN;
            end
            default: begin
                evt.kind = mesd_pkg::KIND_NOOP;
            end
        endcase
    end

    // ticks to frames with saturation
    assign prod = PROD_W'(r_s1_ticks) * PROD_W'(r_fpt);
    assign prod_ext = 64'(prod);
    assign frames = (prod_ext > 64'(mesd_pkg::FRAMES_MAX)) ? mesd_pkg::FRAMES_MAX
                                                          : prod_ext[mesd_pkg::FRAMES_W-1:0];

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fpt <= mesd_pkg::FPT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_fpt <= i_cfg_data;
        end
    end

    // parser state and velocity store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_INFO;
            r_type <= '0;
            r_chan <= '0;
            r_delay <= 1'b0;
            r_first <= '0;
            r_second <= '0;
            r_acc <= '0;
            for (int c = 0; c < CH; c++) begin
                r_vel[c] <= mesd_pkg::VEL_RESET;
            end
        end else begin
            r_phase <= n_phase;
            r_type <= n_type;
            r_chan <= n_chan;
            r_delay <= n_delay;
            r_first <= n_first;
            r_second <= n_second;
            r_acc <= n_acc;
            r_vel <= n_vel;
        end
    end

    // parse stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= emit;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && emit) begin
            r_s1_evt <= evt;
            r_s1_ticks <= emit_ticks;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out.kind <= r_s1_evt.kind;
            r_out.channel <= r_s1_evt.channel;
            r_out.key <= r_s1_evt.key;
            r_out.amount <= r_s1_evt.amount;
            r_out.drum <= r_s1_evt.drum;
            r_out.wait_frames <= frames;
        end
    end

    // checks
    `ASSERT_CLK_MSG(a_s1_kept, i_clk, i_rst_n,
        r_s1_valid && r_out_valid && i_out_stall |=> r_s1_valid, "parse stage event lost")
    `ASSERT_CLK_MSG(a_restart, i_clk, i_rst_n,
        in_acc && i_in.op == mesd_pkg::OP_RESTART |=> r_phase == PH_INFO && !r_s1_valid,
        "restart left parser busy or emitted")
    `ASSERT_CLK(a_delay_start, i_clk, i_rst_n,
        r_phase == PH_DELAY && $past(r_phase) != PH_DELAY |-> r_acc == '0)
    `ASSERT_CLK(a_drum_program, i_clk, i_rst_n,
        r_out_valid && r_out.drum |-> r_out.kind == mesd_pkg::KIND_PROGRAM)

endmodule

/* bench/tb_mus_event_stream_decoder.sv */
// self-checking testbench of the mus event stream decoder
module tb_mus_event_stream_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 280;
    localparam int IDLE_PCT = 7;
    localparam longint unsigned TICK_CAP =
        (64'd1 << mesd_pkg::TICK_BITS_DEFAULT) - 64'd1;

    // midi controller numbers, indexed by mus controller mod 15
    localparam logic [6:0] MIDI_CC [15] = '{
        7'd0, 7'd0, 7'd1, 7'd7, 7'd10, 7'd11, 7'd91, 7'd93,
        7'd64, 7'd67, 7'd120, 7'd123, 7'd126, 7'd127, 7'd121
    };

    typedef enum logic [1:0] {WAIT_INFO, WAIT_DATA1, WAIT_DATA2, WAIT_DELAY} t_parse_phase;

    typedef struct {
        mesd_pkg::t_in  it;
        bit             typed;
        mesd_pkg::t_out want;
    } t_script_row;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           i_in_valid = 1'b0;
    mesd_pkg::t_in  i_in = '0;
    logic           o_in_stall;
    logic           o_out_valid;
    mesd_pkg::t_out o_out;
    logic           i_out_stall = 1'b0;
    logic           i_cfg_valid = 1'b0;
    logic [mesd_pkg::FPT_W-1:0] i_cfg_data = '0;
    logic           o_cfg_ready;

    // decoder shadow state
    logic [mesd_pkg::FPT_W-1:0] fpt_now;
    t_parse_phase     parse_at;
    logic [2:0]       cur_type;
    logic [3:0]       cur_ch;
    logic             delay_on;
    logic [7:0]       first_b;
    logic [6:0]       second_b;
    logic [27:0]      tick_acc;
    logic [6:0]       chan_vel [mesd_pkg::CHANNEL_COUNT];

    mesd_pkg::t_out pending_events [$];
    mesd_pkg::t_in  score_bytes [$];
    t_script_row    script [$];
    int             mismatch_count = 0;
    int             cycle_count = 0;
    bit             calm = 1'b0;

    mus_event_stream_decoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in        (i_in),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_out_stall (i_out_stall),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // run length guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // parser back to info byte, all velocities back to 100
    function automatic void clear_song();
        parse_at = WAIT_INFO;
        cur_type = '0;
        cur_ch = '0;
        delay_on = 1'b0;
        first_b = '0;
        second_b = '0;
        tick_acc = '0;
        for (int c = 0; c < mesd_pkg::CHANNEL_COUNT; c++) begin
            chan_vel[c] = mesd_pkg::VEL_RESET;
        end
    endfunction

    // finished event with its delay scaled to frames
    function automatic mesd_pkg::t_out make_event(logic [27:0] ticks);
        mesd_pkg::t_out r;
        logic [6:0] d1;
        logic [43:0] prod;
        r = '0;
        r.channel = cur_ch;
        d1 = first_b[6:0];
        case (cur_type)
            mesd_pkg::TYPE_OFF: begin
                r.kind = mesd_pkg::KIND_OFF;
                r.key = d1;
            end
            mesd_pkg::TYPE_ON: begin
                r.kind = mesd_pkg::KIND_ON;
                r.key = d1;
                r.amount = 14'(chan_vel[cur_ch]);
            end
            mesd_pkg::TYPE_BEND: begin
                r.kind = mesd_pkg::KIND_BEND;
                r.amount = {first_b, 6'b0};
            end
            mesd_pkg::TYPE_SYS: begin
                r.kind = mesd_pkg::KIND_CONTROL;
                r.key = MIDI_CC[d1 % 15];
            end
            mesd_pkg::TYPE_CTRL: begin
                if (d1 == 7'd0) begin
                    r.kind = mesd_pkg::KIND_PROGRAM;
                    r.key = second_b;
                    r.drum = (cur_ch == mesd_pkg::DRUM_CHANNEL);
                end else begin
                    r.kind = mesd_pkg::KIND_CONTROL;
                    r.key = MIDI_CC[d1 % 15];
                    r.amount = 14'(second_b);
                end
            end
            mesd_pkg::TYPE_UNKNOWN: r.kind = mesd_pkg::KIND_UNKNOWN;
            default: r.kind = mesd_pkg::KIND_NOOP;
        endcase
        prod = 44'(ticks) * 44'(fpt_now);
        r.wait_frames = (prod > 44'(mesd_pkg::FRAMES_MAX)) ? mesd_pkg::FRAMES_MAX
                                                           : prod[mesd_pkg::FRAMES_W-1:0];
        parse_at = WAIT_INFO;
        return r;
    endfunction

    // data bytes done: either start the delay or finish now
    function automatic bit end_of_data(output mesd_pkg::t_out r);
        r = '0;
        if (delay_on) begin
            parse_at = WAIT_DELAY;
            tick_acc = '0;
            return 1'b0;
        end
        r = make_event('0);
        return 1'b1;
    endfunction

    // advance the shadow parser by one transaction, 1 when an event completes
    function automatic bit decode_byte(mesd_pkg::t_in it, output mesd_pkg::t_out r);
        logic [7:0] b;
        longint unsigned t7;
        longint unsigned acc;
        r = '0;
        b = it.score_byte;
        if (it.op == mesd_pkg::OP_RESTART) begin
            clear_song();
            return 1'b0;
        end
        case (parse_at)
            WAIT_INFO: begin
                delay_on = b[7];
                cur_type = b[6:4];
                cur_ch = b[3:0];
                first_b = '0;
                second_b = '0;
                if (cur_type <= mesd_pkg::TYPE_CTRL) begin
                    parse_at = WAIT_DATA1;
                    return 1'b0;
                end
                return end_of_data(r);
            end
            WAIT_DATA1: begin
                first_b = b;
                if ((cur_type == mesd_pkg::TYPE_ON && b[7]) ||
                    cur_type == mesd_pkg::TYPE_CTRL) begin
                    parse_at = WAIT_DATA2;
                    return 1'b0;
                end
                return end_of_data(r);
            end
            WAIT_DATA2: begin
                if (cur_type == mesd_pkg::TYPE_ON) begin
                    chan_vel[cur_ch] = b[6:0];
                end else begin
                    second_b = b[6:0];
                end
                return end_of_data(r);
            end
            default: begin
                t7 = longint'(b[6:0]);
                acc = longint'(tick_acc);
                // tick count saturates instead of wrapping
                if (acc > (TICK_CAP - t7) / 128) begin
                    tick_acc = TICK_CAP[27:0];
                end else begin
                    tick_acc = 28'(acc * 128 + t7);
                end
                if (b[7]) begin
                    return 1'b0;
                end
                r = make_event(tick_acc);
                return 1'b1;
            end
        endcase
    endfunction

    // send one input transaction, then queue what it should produce
    task automatic feed(mesd_pkg::t_in it, bit typed, mesd_pkg::t_out want);
        mesd_pkg::t_out evt;
        bit done;
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in <= it;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        done = decode_byte(it, evt);
        if (typed) begin
            pending_events.push_back(want);
        end else if (done) begin
            pending_events.push_back(evt);
        end
    endtask

    // wait until every expected event is out and the pipeline is empty
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_events.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    // write frames_per_tick while idle
    task automatic write_fpt(logic [mesd_pkg::FPT_W-1:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        fpt_now = v;
    endtask

    function automatic mesd_pkg::t_in score(logic [7:0] b);
        return mesd_pkg::t_in'({mesd_pkg::OP_BYTE, b});
    endfunction

    function automatic t_script_row row(logic op, logic [7:0] b, bit typed = 1'b0,
                                        logic [2:0] kind = '0, logic [3:0] ch = '0,
                                        logic [6:0] key = '0, logic [13:0] amt = '0,
                                        logic drum = 1'b0);
        t_script_row r;
        r.it = mesd_pkg::t_in'({op, b});
        r.typed = typed;
        r.want = mesd_pkg::t_out'({kind, ch, key, amt, drum, {mesd_pkg::FRAMES_W{1'b0}}});
        return r;
    endfunction

    // one random burst: mostly whole events, some noise and restarts
    task automatic build_burst();
        int pick;
        int delay_len;
        logic [2:0] ty;
        logic with_vel;
        pick = $urandom_range(99);
        if (pick < 6) begin
            score_bytes.push_back(score(8'($urandom_range(255))));
        end else if (pick < 9) begin
            score_bytes.push_back(mesd_pkg::t_in'({mesd_pkg::OP_RESTART,
                                                   8'($urandom_range(255))}));
        end else begin
            ty = 3'($urandom_range(7));
            score_bytes.push_back(score({1'($urandom_range(1)), ty, 4'($urandom_range(15))}));
            case (ty)
                mesd_pkg::TYPE_ON: begin
                    with_vel = 1'($urandom_range(1));
                    score_bytes.push_back(score({with_vel, 7'($urandom_range(127))}));
                    if (with_vel) begin
                        score_bytes.push_back(score(8'($urandom_range(255))));
                    end
                end
                mesd_pkg::TYPE_CTRL: begin
                    // program change about a third of the time
                    if ($urandom_range(2) == 0) begin
                        score_bytes.push_back(score({1'($urandom_range(1)), 7'd0}));
                    end else begin
                        score_bytes.push_back(score(8'($urandom_range(255))));
                    end
                    score_bytes.push_back(score(8'($urandom_range(255))));
                end
                mesd_pkg::TYPE_OFF, mesd_pkg::TYPE_BEND, mesd_pkg::TYPE_SYS: begin
                    score_bytes.push_back(score(8'($urandom_range(255))));
                end
                default: ;
            endcase
            if (score_bytes[0].score_byte[7]) begin
                delay_len = ($urandom_range(9) == 0) ? $urandom_range(6, 4)
                                                     : $urandom_range(3, 1);
                for (int i = 0; i < delay_len; i++) begin
                    score_bytes.push_back(score({1'(i != delay_len - 1),
                                                 7'($urandom_range(127))}));
                end
            end
        end
    endtask

    // random phase with one full pause halfway
    task automatic run_random(int n_items);
        int sent;
        bit paused;
        sent = 0;
        paused = 1'b0;
        while (sent < n_items) begin
            build_burst();
            while (score_bytes.size() != 0) begin
                feed(score_bytes.pop_front(), 1'b0, '0);
                sent++;
            end
            if (!paused && sent >= n_items / 2) begin
                drain();
                paused = 1'b1;
            end
        end
    endtask

    // output side: random stall and compare against the oldest expectation
    always @(posedge i_clk) begin
        mesd_pkg::t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_events.size() == 0) begin
                $error("unexpected output transaction kind %0d channel %0d",
                       o_out.kind, o_out.channel);
                mismatch_count++;
            end else begin
                want = pending_events.pop_front();
                if (o_out.kind !== want.kind) begin
                    $error("kind expected %0d actual %0d", want.kind, o_out.kind);
                    mismatch_count++;
                end
                if (o_out.channel !== want.channel) begin
                    $error("channel expected %0d actual %0d", want.channel, o_out.channel);
                    mismatch_count++;
                end
                if (o_out.key !== want.key) begin
                    $error("key expected %0d actual %0d", want.key, o_out.key);
                    mismatch_count++;
                end
                if (o_out.amount !== want.amount) begin
                    $error("amount expected %0d actual %0d", want.amount, o_out.amount);
                    mismatch_count++;
                end
                if (o_out.drum !== want.drum) begin
                    $error("drum expected %0d actual %0d", want.drum, o_out.drum);
                    mismatch_count++;
                end
                if (o_out.wait_frames !== want.wait_frames) begin
                    $error("wait_frames expected %0d actual %0d",
                           want.wait_frames, o_out.wait_frames);
                    mismatch_count++;
                end
            end
        end
        i_out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end

    // stimulus
    initial begin
        logic [mesd_pkg::FPT_W-1:0] fpt_plan [5];

        // directed rows, reset frames_per_tick of 315
        script.push_back(row(mesd_pkg::OP_BYTE, 8'h00));
        script.push_back(row(mesd_pkg::OP_BYTE, 8'hFF, 1, mesd_pkg::KIND_OFF, 4'd0, 7'd127));
        script.push_back(row(mesd_pkg::OP_BYTE, 8'h1F));
        script.push_back(row(mesd_pkg::OP_BYTE, 8'h80));
        script.push_back(row(mesd_pkg::OP_BYTE, 8'h7F, 1, mesd_pkg::KIND_ON, 4'd15, 7'd0,
                             14'd127));
        script.push_back(row(mesd_pkg::OP_BYTE, 8'h2A));
        script.push_back(row(mesd_pkg::OP_BYTE, 8'hFF, 1, mesd_pkg::KIND_BEND, 4'd10, 7'd0,
                             14'd16320));
        // system event with a delay long enough to saturate the tick count
        script.push_back(row(mesd_pkg::OP_BYTE, 8'hB3));
        script.push_back(row(mesd_pkg::OP_BYTE, 8'h0E));
        script.push_back(row(mesd_pkg::OP_BYTE, 8'hFF));
        script.push_back(row(mesd_pkg::OP_BYTE, 8'hFF));
        script.push_back(row(mesd_pkg::OP_BYTE, 8'hFF));
        script.push_back(row(mesd_pkg::OP_BYTE, 8'hFF));
        script.push_back(row(mesd_pkg::OP_BYTE, 8'h7F));
        // program change on the percussion channel
        script.push_back(row(mesd_pkg::OP_BYTE, 8'h49));
        script.push_back(row(mesd_pkg::OP_BYTE, 8'h00));
        script.push_back(row(mesd_pkg::OP_BYTE, 8'h85, 1, mesd_pkg::KIND_PROGRAM, 4'd9, 7'd5,
                             14'd0, 1'b1));
        script.push_back(row(mesd_pkg::OP_BYTE, 8'h50, 1, mesd_pkg::KIND_NOOP, 4'd0));
        script.push_back(row(mesd_pkg::OP_BYTE, 8'hE7));
        script.push_back(row(mesd_pkg::OP_BYTE, 8'h00, 1, mesd_pkg::KIND_NOOP, 4'd7));
        script.push_back(row(mesd_pkg::OP_BYTE, 8'h74, 1, mesd_pkg::KIND_UNKNOWN, 4'd4));
        // restart mid event drops it and brings velocity back to 100
        script.push_back(row(mesd_pkg::OP_BYTE, 8'h1F));
        script.push_back(row(mesd_pkg::OP_BYTE, 8'h80));
        script.push_back(row(mesd_pkg::OP_RESTART, 8'hAA));
        script.push_back(row(mesd_pkg::OP_BYTE, 8'h1F));
        script.push_back(row(mesd_pkg::OP_BYTE, 8'h3C, 1, mesd_pkg::KIND_ON, 4'd15, 7'd60,
                             14'd100));

        fpt_plan = '{16'hFFFF, 16'd1, 16'd0, 16'($urandom_range(65535, 1)),
                     mesd_pkg::FPT_RESET};

        fpt_now = mesd_pkg::FPT_RESET;
        clear_song();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[i]) begin
            feed(script[i].it, script[i].typed, script[i].want);
        end
        drain();

        // random phases over several frames_per_tick settings
        for (int p = 0; p < 5; p++) begin
            write_fpt(fpt_plan[p]);
            calm = (p == 1);
            run_random(PHASE_ITEMS);
            drain();
        end
        calm = 1'b0;

        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
